[design/braille_keypad_code_decoder_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the braille keypad code decoder
// ----------------------------------------------------------------------------
`ifndef BRAILLE_KEYPAD_CODE_DECODER_TOP_ASSERT_SVH
`define BRAILLE_KEYPAD_CODE_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define BKCD_ASSERT_NOW(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("bkcd assertion failed");

// next-cycle implication
`define BKCD_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("bkcd assertion failed");

`endif

[design/bkcd_pkg.sv]
// ----------------------------------------------------------------------------
// Braille keypad code decoder package
// Key-code constants, event and command codes, result type
// ----------------------------------------------------------------------------
package bkcd_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int CELL_W  = 7;
    localparam int CMD_W   = 2;
    localparam int DOTS_W  = 8;

    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CURSOR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CMD    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SPACE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CHORD  = 3'd4;

    localparam logic [CMD_W-1:0] CMD_BACKWARD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FORWARD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ESCAPE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RETURN   = 2'd3;

    localparam logic [BYTE_W-1:0] CODE_ACK          = 8'h7E;
    localparam logic [BYTE_W-1:0] CODE_CURSOR_LO    = 8'h20;
    localparam logic [BYTE_W-1:0] CODE_CURSOR_HI    = 8'h6F;
    localparam logic [BYTE_W-1:0] CODE_CUR_REL_LO   = 8'hA0;
    localparam logic [BYTE_W-1:0] CODE_CUR_REL_HI   = 8'hEF;
    localparam logic [BYTE_W-1:0] CODE_RELEASE_LO   = 8'h83;
    localparam logic [BYTE_W-1:0] CODE_DOT_REL_HI   = 8'h9F;
    localparam logic [BYTE_W-1:0] CODE_BACKWARD     = 8'h04;
    localparam logic [BYTE_W-1:0] CODE_FORWARD      = 8'h08;
    localparam logic [BYTE_W-1:0] CODE_ESCAPE       = 8'h0C;
    localparam logic [BYTE_W-1:0] CODE_RETURN       = 8'h14;
    localparam logic [BYTE_W-1:0] CODE_SPACE        = 8'h10;
    localparam logic [1:0]        DOT_KEY_TAG       = 2'b11;

    typedef struct packed {
        logic              reported;
        logic [KIND_W-1:0] event_kind;
        logic [CELL_W-1:0] cursor_cell;
        logic [CMD_W-1:0]  command_code;
        logic [DOTS_W-1:0] dots;
    } bkcd_result_t;

    // dot bit for press codes 0x03 + 4*i
    function automatic logic [DOTS_W-1:0] dot_bit(input logic [2:0] idx);
        logic [DOTS_W-1:0] b;
        case (idx)
            3'd0:    b = 8'h40;
            3'd1:    b = 8'h04;
            3'd2:    b = 8'h02;
            3'd3:    b = 8'h01;
            3'd4:    b = 8'h08;
            3'd5:    b = 8'h10;
            3'd6:    b = 8'h20;
            3'd7:    b = 8'h80;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

[design/bkcd_decode.sv]
// ----------------------------------------------------------------------------
// Key-code decode
// Maps one key-code byte and the held chord to a result and the next chord
// ----------------------------------------------------------------------------
module bkcd_decode (
    input  logic [bkcd_pkg::BYTE_W-1:0] rx_byte,
    input  logic [bkcd_pkg::DOTS_W-1:0] chord,
    output bkcd_pkg::bkcd_result_t      result,
    output logic [bkcd_pkg::DOTS_W-1:0] chord_next
);
    import bkcd_pkg::*;

    logic [BYTE_W-1:0] cell_full;

    assign cell_full = rx_byte - CODE_CURSOR_LO;

    always_comb
    begin
        result     = '0;
        chord_next = chord;
        if (rx_byte == CODE_ACK)
        begin
            chord_next = chord;
        end
        else if (rx_byte inside {[CODE_CURSOR_LO:CODE_CURSOR_HI]})
        begin
            result.reported    = 1'b1;
            result.event_kind  = KIND_CURSOR;
            result.cursor_cell = cell_full[CELL_W-1:0];
            chord_next         = '0;
        end
        else if (rx_byte inside {[CODE_CUR_REL_LO:CODE_CUR_REL_HI]})
        begin
            chord_next = '0;
        end
        else if (rx_byte < CODE_CURSOR_LO)
        begin
            if (rx_byte[1:0] == DOT_KEY_TAG)
            begin
                chord_next      = chord | dot_bit(rx_byte[4:2]);
                result.reported = 1'b1;
            end
            else
            begin
                case (rx_byte)
                    CODE_BACKWARD:
                    begin
                        result.reported     = 1'b1;
                        result.event_kind   = KIND_CMD;
                        result.command_code = CMD_BACKWARD;
                        chord_next          = '0;
                    end
                    CODE_FORWARD:
                    begin
                        result.reported     = 1'b1;
                        result.event_kind   = KIND_CMD;
                        result.command_code = CMD_FORWARD;
                        chord_next          = '0;
                    end
                    CODE_ESCAPE:
                    begin
                        result.reported     = 1'b1;
                        result.event_kind   = KIND_CMD;
                        result.command_code = CMD_ESCAPE;
                        chord_next          = '0;
                    end
                    CODE_RETURN:
                    begin
                        result.reported     = 1'b1;
                        result.event_kind   = KIND_CMD;
                        result.command_code = CMD_RETURN;
                        chord_next          = '0;
                    end
                    CODE_SPACE:
                    begin
                        result.reported   = 1'b1;
                        result.event_kind = KIND_SPACE;
                        chord_next        = '0;
                    end
                    default:
                    begin
                        chord_next = chord;
                    end
                endcase
            end
        end
        else if (rx_byte >= CODE_RELEASE_LO)
        begin
            if ((rx_byte <= CODE_DOT_REL_HI) && (rx_byte[1:0] == DOT_KEY_TAG))
            begin
                if (chord != '0)
                begin
                    result.reported   = 1'b1;
                    result.event_kind = KIND_CHORD;
                    result.dots       = chord;
                    chord_next        = '0;
                end
            end
            else
            begin
                chord_next = '0;
            end
        end
    end

endmodule

[design/braille_keypad_code_decoder_top.sv]
// path: an input beat is held in the input register, then its result in the result register
// throughput: one key-code byte per cycle while out_ready allows it, set by the single-pass decode stage
// the chord register updates as a byte moves from the input to the result register
// reset: rst_n asynchronous active low, clears both valid flags and the chord
// ----------------------------------------------------------------------------
// Braille keypad code decoder top
// Two-stage pipeline around the key-code decode with the held dot chord
// ----------------------------------------------------------------------------
`include "braille_keypad_code_decoder_top_assert.svh"

module braille_keypad_code_decoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bkcd_pkg::BYTE_W-1:0]   rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          reported,
    output logic [bkcd_pkg::KIND_W-1:0]   event_kind,
    output logic [bkcd_pkg::CELL_W-1:0]   cursor_cell,
    output logic [bkcd_pkg::CMD_W-1:0]    command_code,
    output logic [bkcd_pkg::DOTS_W-1:0]   dots
);
    import bkcd_pkg::*;

    logic              stage_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              out_valid_reg;
    bkcd_result_t      result_reg;
    logic [DOTS_W-1:0] chord_reg;
    logic [DOTS_W-1:0] chord_next;
    bkcd_result_t      result_next;
    logic              advance;
    logic              in_beat;

    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;
    assign in_beat  = in_valid && in_ready;

    bkcd_decode u_decode (
        .rx_byte    (byte_reg),
        .chord      (chord_reg),
        .result     (result_next),
        .chord_next (chord_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            chord_reg       <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                chord_reg     <= chord_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            byte_reg <= rx_byte;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign reported     = result_reg.reported;
    assign event_kind   = result_reg.event_kind;
    assign cursor_cell  = result_reg.cursor_cell;
    assign command_code = result_reg.command_code;
    assign dots         = result_reg.dots;

    // chord is emptied after it is emitted
    `BKCD_ASSERT_NEXT(a_chord_clear, clk, rst_n, advance && (result_next.event_kind == KIND_CHORD), chord_reg == '0)
    // chord only changes when a byte moves to the result register
    `BKCD_ASSERT_NEXT(a_chord_hold, clk, rst_n, !advance, $stable(chord_reg))
    // any event kind implies the byte was reported
    `BKCD_ASSERT_NOW(a_event_reported, clk, rst_n, out_valid_reg && (result_reg.event_kind != KIND_NONE), result_reg.reported)
    // dots only carried by a chord event
    `BKCD_ASSERT_NOW(a_dots_chord_only, clk, rst_n, out_valid_reg && (result_reg.event_kind != KIND_CHORD), result_reg.dots == '0)

endmodule
